### rtl/xenc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package xenc_pkg;

   localparam int CodeStoreBytes = 8388608;
   localparam int PosWidth = 24;
   localparam int MaxBytes = 10;

   localparam logic [6:0] OpJmpIdx   = 7'd86;
   localparam logic [6:0] OpLoadIdx  = 7'd87;
   localparam logic [6:0] OpLoadSib  = 7'd88;
   localparam logic [6:0] OpStoreIdx = 7'd89;
   localparam logic [6:0] OpRestart  = 7'd90;
   localparam logic [6:0] OpLastGen  = 7'd85;
   localparam logic [6:0] OpAddi     = 7'd1;
   localparam logic [6:0] OpAddim    = 7'd2;
   localparam logic [6:0] OpSubi     = 7'd78;
   localparam logic [6:0] OpCall     = 7'd16;
   localparam logic [6:0] OpJmpRel   = 7'd36;

   typedef struct packed {
      logic [6:0]  operation;
      logic [31:0] dst_operand;
      logic [31:0] src_operand;
      logic [2:0]  index_register;
      logic [3:0]  scale_factor;
   } req_type;

   typedef struct packed {
      logic [7:0]  code_byte;
      logic [23:0] byte_offset;
      logic        last_byte;
      logic        overflow;
      logic        bad_operation;
      logic [31:0] instruction_count;
   } rsp_type;

   // one encoded operation, bytes in emission order
   typedef struct packed {
      logic [MaxBytes-1:0][7:0] bytes;
      logic [3:0]               len;
      logic                     bad;
      logic                     restart;
      logic [31:0]              count;
   } cmd_type;

endpackage
`default_nettype wire

### rtl/xenc_front.sv
`timescale 1ns / 1ps
`default_nettype none
module xenc_front import xenc_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   input  wire req_type  in_req,
   input  wire logic     stage_ready,
   output logic          stage_valid,
   output cmd_type       stage_cmd
);

   logic                     valid_ff;
   cmd_type                  cmd_ff;
   logic [31:0]              count_ff;
   logic [MaxBytes-1:0][7:0] bb;
   logic [3:0]               n;
   cmd_type                  cmd_in;
   logic                     take;

   assign take = in_valid && (!valid_ff || stage_ready);

   always_comb begin
      logic [31:0] us;
      logic [31:0] ud;
      logic [2:0]  d;
      logic [2:0]  r;
      logic        f8;
      logic [1:0]  sc;
      logic [6:0]  op;
      us = in_req.src_operand;
      ud = in_req.dst_operand;
      op = in_req.operation;
      d  = ud[2:0];
      r  = us[2:0];
      f8 = (us[31:7] == 25'h0) || (us[31:7] == 25'h1ffffff);
      sc = (in_req.scale_factor == 4'd2) ? 2'd1 : (in_req.scale_factor == 4'd4) ? 2'd2 :
           (in_req.scale_factor == 4'd8) ? 2'd3 : 2'd0;
      bb = '0;
      n  = 4'd0;
      // opcode table; displacement bytes for relative forms are left to the back end
      unique case (op)
         7'd0:  begin bb[0]=8'h01; bb[1]={2'b11,r,d}; n=4'd2; end
         7'd1, 7'd5, 7'd8, 7'd23, 7'd59, 7'd78, 7'd84: begin
            logic [7:0] m;
            unique case (op)
               7'd1:  m = 8'hc0;
               7'd5:  m = 8'hd0;
               7'd8:  m = 8'he0;
               7'd23: m = 8'hf8;
               7'd59: m = 8'hc8;
               7'd78: m = 8'he8;
               default: m = 8'hf0;
            endcase
            bb[1] = m | {5'd0, d};
            if (f8) begin bb[0]=8'h83; bb[2]=us[7:0]; n=4'd3; end
            else begin bb[0]=8'h81; bb[5:2]=us; n=4'd6; end
         end
         7'd2, 7'd9, 7'd24, 7'd60, 7'd79: begin
            unique case (op)
               7'd2:  bb[1] = 8'h05;
               7'd9:  bb[1] = 8'h25;
               7'd24: bb[1] = 8'h3d;
               7'd60: bb[1] = 8'h0d;
               default: bb[1] = 8'h2d;
            endcase
            bb[5:2] = ud;
            if (f8) begin bb[0]=8'h83; bb[6]=us[7:0]; n=4'd7; end
            else begin bb[0]=8'h81; bb[9:6]=us; n=4'd10; end
         end
         7'd3:  begin bb[0]=8'h03; bb[1]={2'b00,d,3'd5}; bb[5:2]=us; n=4'd6; end
         7'd4:  begin bb[0]=8'h11; bb[1]={2'b11,r,d}; n=4'd2; end
         7'd6:  begin bb[0]=8'h13; bb[1]={2'b00,d,3'd5}; bb[5:2]=us; n=4'd6; end
         7'd7:  begin bb[0]=8'h21; bb[1]={2'b11,r,d}; n=4'd2; end
         7'd10: begin bb[0]=8'h23; bb[1]={2'b00,d,3'd5}; bb[5:2]=us; n=4'd6; end
         7'd11: begin bb[0]=8'h0f; bb[1]=8'hbd; bb[2]={2'b11,d,r}; n=4'd3; end
         7'd12: begin bb[0]=8'h0f; bb[1]={5'b11001,d}; n=4'd2; end
         7'd13: begin bb[0]=8'h0f; bb[1]=8'hba; bb[2]=8'h25; bb[6:3]=ud; bb[7]=us[7:0];
                      n=4'd8; end
         7'd14: begin bb[0]=8'h0f; bb[1]=8'hba; bb[2]={5'b11110,d}; bb[3]=us[7:0];
                      n=4'd4; end
         7'd15: begin bb[0]=8'hff; bb[1]={5'b11010,d}; n=4'd2; end
         7'd16: begin bb[0]=8'he8; n=4'd5; end
         7'd17, 7'd18, 7'd19, 7'd20, 7'd21: begin
            bb[0] = 8'h0f;
            unique case (op)
               7'd17: bb[1] = 8'h47;
               7'd18: bb[1] = 8'h42;
               7'd19: bb[1] = 8'h4f;
               7'd20: bb[1] = 8'h4c;
               default: bb[1] = 8'h44;
            endcase
            bb[2] = {2'b00,d,3'd5}; bb[6:3] = us; n = 4'd7;
         end
         7'd22: begin bb[0]=8'h39; bb[1]={2'b11,r,d}; n=4'd2; end
         7'd25: begin bb[0]=8'h3b; bb[1]={2'b00,d,3'd5}; bb[5:2]=us; n=4'd6; end
         7'd26: begin bb[0]=8'hf2; bb[1]=8'h0f; bb[2]=8'h5a; bb[3]={2'b11,d,r}; n=4'd4; end
         7'd27: begin bb[0]=8'hf3; bb[1]=8'h0f; bb[2]=8'h5a; bb[3]={2'b11,d,r}; n=4'd4; end
         7'd28: begin bb[0]=8'hd9; bb[1]=8'he1; n=4'd2; end
         7'd29: begin bb[0]=8'hd9; bb[1]=8'he0; n=4'd2; end
         7'd30: begin bb[0]=8'hdc; bb[1]=8'h05; bb[5:2]=ud; n=4'd6; end
         7'd31: begin bb[0]=8'hdc; bb[1]=8'h35; bb[5:2]=ud; n=4'd6; end
         7'd32: begin bb[0]=8'hdd; bb[1]=8'h05; bb[5:2]=ud; n=4'd6; end
         7'd33: begin bb[0]=8'hdd; bb[1]=8'h1d; bb[5:2]=ud; n=4'd6; end
         7'd34: begin bb[0]=8'hf7; bb[1]={5'b11111,d}; n=4'd2; end
         7'd35: begin bb[0]=8'hf7; bb[1]={5'b11101,d}; n=4'd2; end
         7'd36: begin bb[0]=8'he9; n=4'd5; end
         7'd37: begin bb[0]=8'hff; bb[1]=8'h25; bb[5:2]=ud; n=4'd6; end
         7'd38: begin bb[0]=8'hff; bb[1]={5'b11100,d}; n=4'd2; end
         7'd39: begin bb[0]=8'h89; bb[1]={2'b11,r,d}; n=4'd2; end
         7'd40: begin bb[0]=8'hc7; bb[1]={5'b11000,d}; bb[5:2]=us; n=4'd6; end
         7'd41: begin bb[0]=8'hc7; bb[1]=8'h05; bb[5:2]=ud; bb[9:6]=us; n=4'd10; end
         7'd42: begin bb[0]=8'h8b; bb[1]={2'b00,d,3'd5}; bb[5:2]=us; n=4'd6; end
         7'd43: begin bb[0]=8'h89; bb[1]={2'b00,r,3'd5}; bb[5:2]=ud; n=4'd6; end
         7'd44: begin bb[0]=8'h88; bb[1]={2'b00,r,3'd5}; bb[5:2]=ud; n=4'd6; end
         7'd45: begin bb[0]=8'h8a; bb[1]={2'b00,d,3'd5}; bb[5:2]=us; n=4'd6; end
         7'd46: begin bb[0]=8'h0f; bb[1]=8'hbe; bb[2]={2'b11,d,r}; n=4'd3; end
         7'd47: begin bb[0]=8'h0f; bb[1]=8'hbf; bb[2]={2'b11,d,r}; n=4'd3; end
         7'd48: begin bb[0]=8'h0f; bb[1]=8'hb6; bb[2]={2'b00,d,3'd5}; bb[6:3]=us;
                      n=4'd7; end
         7'd49: begin bb[0]=8'h0f; bb[1]=8'hb6; bb[2]={2'b11,d,r}; n=4'd3; end
         7'd50: begin bb[0]=8'h0f; bb[1]=8'hb7; bb[2]={2'b11,d,r}; n=4'd3; end
         7'd51: begin bb[0]=8'h66; bb[1]=8'h0f; bb[2]=8'h6e; bb[3]={2'b11,d,r}; n=4'd4; end
         7'd52: begin bb[0]=8'h66; bb[1]=8'h0f; bb[2]=8'h7e; bb[3]={2'b11,r,d}; n=4'd4; end
         7'd53: begin bb[0]=8'hf3; bb[1]=8'h0f; bb[2]=8'h7e; bb[3]={2'b00,d,3'd5};
                      bb[7:4]=us; n=4'd8; end
         7'd54: begin bb[0]=8'h66; bb[1]=8'h0f; bb[2]=8'hd6; bb[3]={2'b00,r,3'd5};
                      bb[7:4]=ud; n=4'd8; end
         7'd55: begin bb[0]=8'hf7; bb[1]={5'b11100,d}; n=4'd2; end
         7'd56: begin bb[0]=8'hf7; bb[1]={5'b11011,d}; n=4'd2; end
         7'd57: begin bb[0]=8'hf7; bb[1]={5'b11010,d}; n=4'd2; end
         7'd58: begin bb[0]=8'h09; bb[1]={2'b11,r,d}; n=4'd2; end
         7'd61: begin bb[0]=8'h0b; bb[1]={2'b00,d,3'd5}; bb[5:2]=us; n=4'd6; end
         7'd62: begin bb[0]={5'b01011,d}; n=4'd1; end
         7'd63: begin bb[0]=8'h61; n=4'd1; end
         7'd64: begin bb[0]={5'b01010,d}; n=4'd1; end
         7'd65: begin bb[0]=8'h68; bb[4:1]=ud; n=4'd5; end
         7'd66: begin bb[0]=8'h60; n=4'd1; end
         7'd67: begin bb[0]=8'hc3; n=4'd1; end
         7'd68: begin bb[0]=8'hd3; bb[1]={5'b11000,d}; n=4'd2; end
         7'd69, 7'd74, 7'd76: begin
            logic [7:0] m;
            unique case (op)
               7'd69: m = 8'hc0;
               7'd74: m = 8'he0;
               default: m = 8'he8;
            endcase
            bb[1] = m | {5'd0, d};
            if (us == 32'd1) begin bb[0]=8'hd1; n=4'd2; end
            else begin bb[0]=8'hc1; bb[2]=us[7:0]; n=4'd3; end
         end
         7'd70: begin bb[0]=8'h0f; bb[1]=8'h92; bb[2]={5'b11000,d}; n=4'd3; end
         7'd71: begin bb[0]=8'h0f; bb[1]=8'h93; bb[2]={5'b11000,d}; n=4'd3; end
         7'd72: begin bb[0]=8'h0f; bb[1]=8'h94; bb[2]={5'b11000,d}; n=4'd3; end
         7'd73: begin bb[0]=8'hd3; bb[1]={5'b11100,d}; n=4'd2; end
         7'd75: begin bb[0]=8'hd3; bb[1]={5'b11101,d}; n=4'd2; end
         7'd77: begin bb[0]=8'h29; bb[1]={2'b11,r,d}; n=4'd2; end
         7'd80: begin bb[0]=8'h2b; bb[1]={2'b00,d,3'd5}; bb[5:2]=us; n=4'd6; end
         7'd81: begin
            bb[1] = {5'b11000,d};
            if (f8) begin bb[0]=8'hf6; bb[2]=us[7:0]; n=4'd3; end
            else begin bb[0]=8'hf7; bb[5:2]=us; n=4'd6; end
         end
         7'd82: begin bb[0]=8'h86; bb[1]={2'b11,d,r}; n=4'd2; end
         7'd83: begin bb[0]=8'h31; bb[1]={2'b11,r,d}; n=4'd2; end
         7'd85: begin bb[0]=8'h33; bb[1]={2'b00,d,3'd5}; bb[5:2]=us; n=4'd6; end
         OpJmpIdx: begin bb[0]=8'hff; bb[1]=8'h24; bb[2]={2'b00,in_req.index_register,d};
                         n=4'd3; end
         OpLoadIdx: begin bb[0]=8'h8b; bb[1]={2'b10,d,in_req.index_register};
                          bb[5:2]=us; n=4'd6; end
         OpLoadSib: begin bb[0]=8'h8b; bb[1]={2'b00,d,3'd4};
                          bb[2]={sc,in_req.index_register,3'd5}; bb[6:3]=us; n=4'd7; end
         OpStoreIdx: begin bb[0]=8'h89; bb[1]={2'b10,d,in_req.index_register};
                           bb[5:2]=us; n=4'd6; end
         default: begin bb = '0; n = 4'd0; end
      endcase
      // add or subtract of zero emits nothing
      if ((op == OpAddi || op == OpAddim || op == OpSubi) && us == 32'd0) n = 4'd0;
      // relative forms carry the target in the displacement slot for the back end
      if (op == OpCall || op == OpJmpRel) bb[4:1] = ud;
      cmd_in.bytes   = bb;
      cmd_in.len     = n;
      cmd_in.bad     = op > OpRestart;
      cmd_in.restart = op == OpRestart;
      cmd_in.count   = (op <= OpLastGen) ? count_ff + 32'd1 : count_ff;
      if (op > OpRestart) cmd_in.len = 4'd1;
   end

   // classification register and operation count
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         if (take) begin
            valid_ff <= 1'b1;
            count_ff <= cmd_in.count;
         end else if (stage_ready) begin
            valid_ff <= 1'b0;
         end
      end
      if (take) cmd_ff <= cmd_in;
   end

   assign stage_valid = valid_ff;
   assign stage_cmd   = cmd_ff;

endmodule
`default_nettype wire

### rtl/xenc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module xenc_queue import xenc_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    wr_valid,
   input  wire cmd_type wr_cmd,
   output logic         wr_ready,
   output logic         rd_valid,
   output cmd_type      rd_cmd,
   input  wire logic    rd_ready
);

   cmd_type    slot_ff [2];
   logic       wptr_ff;
   logic       rptr_ff;
   logic [1:0] fill_ff;
   logic       push;
   logic       pop;

   assign wr_ready = fill_ff != 2'd2;
   assign rd_valid = fill_ff != 2'd0;
   assign rd_cmd   = slot_ff[rptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   // two-entry command queue
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         fill_ff <= '0;
      end else begin
         if (push) wptr_ff <= ~wptr_ff;
         if (pop) rptr_ff <= ~rptr_ff;
         fill_ff <= fill_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) slot_ff[wptr_ff] <= wr_cmd;
   end

endmodule
`default_nettype wire

### rtl/xenc_back.sv
`timescale 1ns / 1ps
`default_nettype none
module xenc_back import xenc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [31:0] code_base,
   input  wire logic        cmd_valid,
   input  wire cmd_type     cmd,
   output logic             cmd_ready,
   output logic             out_valid,
   output rsp_type          out_rsp,
   input  wire logic        out_ready
);

   localparam logic [PosWidth-1:0] StoreFull = PosWidth'(CodeStoreBytes);

   logic [PosWidth-1:0] pos_ff;
   logic [PosWidth-1:0] pos_in;
   logic [3:0]          idx_ff;
   logic [3:0]          idx_in;
   logic [31:0]         rel_ff;
   logic [31:0]         rel_in;
   logic                valid_ff;
   rsp_type             rsp_ff;
   rsp_type             rsp_in;
   logic                slot_free;
   logic                emit;
   logic                done;
   logic                full;
   logic                relative;
   logic [7:0]          byte_sel;

   assign slot_free = !valid_ff || out_ready;
   assign full      = pos_ff >= StoreFull;
   assign relative  = cmd.bytes[0] == 8'he8 || cmd.bytes[0] == 8'he9;
   // relative displacement formed on the first byte, from the position at operation start
   assign rel_in    = cmd.bytes[4:1] - (code_base + {8'd0, pos_ff} + 32'd5);
   assign emit      = cmd_valid && slot_free && !cmd.restart && cmd.len != 4'd0;
   assign done      = cmd_valid && (cmd.restart || cmd.len == 4'd0 ||
                      (emit && idx_ff == cmd.len - 4'd1));
   assign cmd_ready = done;

   always_comb begin
      byte_sel = cmd.bytes[idx_ff];
      if (relative && !cmd.bad && idx_ff != 4'd0) begin
         byte_sel = (idx_ff == 4'd1) ? rel_ff[7:0] : (idx_ff == 4'd2) ? rel_ff[15:8] :
                    (idx_ff == 4'd3) ? rel_ff[23:16] : rel_ff[31:24];
      end
      rsp_in.code_byte         = cmd.bad ? 8'd0 : byte_sel;
      rsp_in.byte_offset       = (full && !cmd.bad) ? StoreFull : pos_ff;
      rsp_in.last_byte         = idx_ff == cmd.len - 4'd1;
      rsp_in.overflow          = full && !cmd.bad;
      rsp_in.bad_operation     = cmd.bad;
      rsp_in.instruction_count = cmd.count;
      pos_in = pos_ff;
      if (cmd_valid && cmd.restart) pos_in = '0;
      else if (emit && !full && !cmd.bad) pos_in = pos_ff + PosWidth'(1);
      idx_in = done ? 4'd0 : (emit ? idx_ff + 4'd1 : idx_ff);
   end

   // byte sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         idx_ff <= idx_in;
         if (emit) valid_ff <= 1'b1;
         else if (out_ready) valid_ff <= 1'b0;
      end
      if (emit) begin
         rsp_ff <= rsp_in;
         if (idx_ff == 4'd0) rel_ff <= rel_in;
      end
   end

   // first byte of a relative form is the opcode, so the held displacement is ready in time
   assign out_valid = valid_ff;
   assign out_rsp   = rsp_ff;

endmodule
`default_nettype wire

### rtl/x86_instruction_byte_encoder.sv
`timescale 1ns / 1ps
`default_nettype none
// an operation passes the front classification register, the command queue
// and the back end output register; throughput: one byte per cycle from the back end
// sequencer while the output is taken; an operation has 0 to 10 bytes
// reset: synchronous, clears write position, operation count, queues and code_base
module x86_instruction_byte_encoder import xenc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire req_type     req_data,
   output logic             empty,
   input  wire logic        pop,
   output rsp_type          rsp_data,
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data
);

   logic [31:0] code_base_ff;
   logic        f_valid;
   cmd_type     f_cmd;
   logic        q_ready;
   logic        q_valid;
   cmd_type     q_cmd;
   logic        b_ready;
   logic        o_valid;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) code_base_ff <= '0;
      else if (csr_wr_en) code_base_ff <= csr_wr_data;
   end

   assign full = f_valid && !q_ready;

   xenc_front u_front (
      .clock(clock), .reset(reset), .in_valid(push), .in_req(req_data),
      .stage_ready(q_ready), .stage_valid(f_valid), .stage_cmd(f_cmd)
   );

   xenc_queue u_queue (
      .clock(clock), .reset(reset), .wr_valid(f_valid), .wr_cmd(f_cmd),
      .wr_ready(q_ready), .rd_valid(q_valid), .rd_cmd(q_cmd), .rd_ready(b_ready)
   );

   xenc_back u_back (
      .clock(clock), .reset(reset), .code_base(code_base_ff), .cmd_valid(q_valid),
      .cmd(q_cmd), .cmd_ready(b_ready), .out_valid(o_valid), .out_rsp(rsp_data),
      .out_ready(pop)
   );

   assign empty = !o_valid;

   // a bad operation byte never reports overflow and is always the last byte
   assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_data.bad_operation |-> !rsp_data.overflow && rsp_data.last_byte)
      else $error("bad operation result malformed");

   // a waiting result holds while not taken
   assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_data))
      else $error("result changed while stalled");

   // overflow bytes sit at the end of the store
   assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_data.overflow |-> rsp_data.byte_offset == PosWidth'(CodeStoreBytes))
      else $error("overflow offset wrong");

endmodule
`default_nettype wire
